FILE: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue: request modes, result
// status codes and the per-row cell control group.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int WORD_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 8;
   localparam int CAP_W    = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Control for one row of cells. The near end of a row is cell 0.
   typedef struct packed {
      logic push_near;   // shift away from cell 0, new word into cell 0
      logic pop_near;    // shift toward cell 0
      logic load_far;    // write the new word into the cell at the fill count
   } dq_ctl_type;

endpackage

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of 32-bit words built from two mirrored rows of cells.
//
//   Channel  Dir  Handshake            Payload (low bit first)
//   req      in   req_tvalid/tready    mode[1:0], push_value[33:2]
//   rsp      out  rsp_tvalid/tready    status[1:0], pop_value[33:2],
//                                      fill_count[41:34]
//   csr      in   csr_wr_en            capacity_limit[7:0]
//
// One request per cycle; its result appears in the output register the
// next cycle. The front row keeps the front word in cell 0, the rear row
// keeps the rear word in cell 0, so every pop reads a fixed cell and every
// push is one shift in one row plus one indexed write in the other.
// A new request is taken while the output register is empty or being read.
// Reset empties the queue and sets the capacity to 128; no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mode[1:0], push_value[33:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], pop_value[33:2], fill_count[41:34]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [CAP_W-1:0]    cap_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [WORD_W-1:0]   rsp_pop_ff;
   logic [WORD_W-1:0]   rsp_pop_in;
   logic [FILL_W-1:0]   rsp_fill_ff;
   logic [FILL_W-1:0]   rsp_fill_in;

   logic                accept;
   mode_type            mode;
   logic [WORD_W-1:0]   push_value;
   logic                full;
   logic                empty;
   logic                push_front_ok;
   logic                push_rear_ok;
   logic                pop_front_ok;
   logic                pop_rear_ok;
   dq_ctl_type          front_ctl;
   dq_ctl_type          rear_ctl;
   logic [WORD_W-1:0]   front_head;
   logic [WORD_W-1:0]   rear_head;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = mode_type'(req_tdata[1:0]);
   assign push_value = req_tdata[33:2];

   assign full  = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   assign push_front_ok = accept && (mode == MODE_PUSH_FRONT) && !full;
   assign push_rear_ok  = accept && (mode == MODE_PUSH_REAR)  && !full;
   assign pop_front_ok  = accept && (mode == MODE_POP_FRONT)  && !empty;
   assign pop_rear_ok   = accept && (mode == MODE_POP_REAR)   && !empty;

   always_comb begin
      front_ctl.push_near = push_front_ok;
      front_ctl.pop_near  = pop_front_ok;
      front_ctl.load_far  = push_rear_ok;
      rear_ctl.push_near  = push_rear_ok;
      rear_ctl.pop_near   = pop_rear_ok;
      rear_ctl.load_far   = push_front_ok;
   end

   dq_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_front (
      .clock     (clock),
      .ctl       (front_ctl),
      .fill      (count_ff),
      .new_word  (push_value),
      .head_word (front_head)
   );

   dq_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_rear (
      .clock     (clock),
      .ctl       (rear_ctl),
      .fill      (count_ff),
      .new_word  (push_value),
      .head_word (rear_head)
   );

   always_comb begin
      count_in      = count_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pop_in    = rsp_pop_ff;
      rsp_fill_in   = rsp_fill_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      if (push_front_ok || push_rear_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_front_ok || pop_rear_ok) begin
         count_in = count_ff - CW'(1);
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_pop_in   = '0;
         rsp_fill_in  = FILL_W'(CMPW'(count_in));
         case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
               rsp_status_in = full ? STATUS_FULL : STATUS_DONE;
            end
            MODE_POP_FRONT: begin
               rsp_status_in = empty ? STATUS_EMPTY : STATUS_DONE;
               if (!empty) begin
                  rsp_pop_in = front_head;
               end
            end
            MODE_POP_REAR: begin
               rsp_status_in = empty ? STATUS_EMPTY : STATUS_DONE;
               if (!empty) begin
                  rsp_pop_in = rear_head;
               end
            end
            default: begin
               rsp_status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_pop_ff    <= rsp_pop_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_fill_ff, rsp_pop_ff, rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_single_word_rows_agree: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'(1) |-> front_head == rear_head)
      else $error("front and rear rows disagree on the only word");

   a_refused_push_holds: assert property (@(posedge clock) disable iff (reset)
      accept && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR)
      |=> count_ff == $past(count_ff))
      else $error("refused push changed the count");

   a_pop_front_value: assert property (@(posedge clock) disable iff (reset)
      pop_front_ok |=> rsp_pop_ff == $past(front_head))
      else $error("front pop returned the wrong word");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transfer accepted without a result");

endmodule

FILE: rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of a row: holds one word and takes it from a neighbor,
// from the broadcast word, or keeps it.
// ----------------------------------------------------------------------------
module dq_cell
   import dq_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 8
) (
   input  logic              clock,
   input  dq_ctl_type        ctl,
   input  logic [CW-1:0]     fill,
   input  logic [WORD_W-1:0] near_word,
   input  logic [WORD_W-1:0] far_word,
   input  logic [WORD_W-1:0] load_word,
   output logic [WORD_W-1:0] word
);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.push_near) begin
         data_in = near_word;
      end else if (ctl.pop_near) begin
         data_in = far_word;
      end else if (ctl.load_far && (fill == CW'(INDEX))) begin
         data_in = load_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word = data_ff;

endmodule

FILE: rtl/dq_chain.sv
// ----------------------------------------------------------------------------
// dq_chain
// Row of DEPTH cells; each cell hands its word to a neighbor on a shift.
// The word at the near end is presented at head_word.
// ----------------------------------------------------------------------------
module dq_chain
   import dq_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int CW    = 8
) (
   input  logic              clock,
   input  dq_ctl_type        ctl,
   input  logic [CW-1:0]     fill,
   input  logic [WORD_W-1:0] new_word,
   output logic [WORD_W-1:0] head_word
);

   logic [WORD_W-1:0] cell_word [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] near_word;
      logic [WORD_W-1:0] far_word;

      if (i == 0) begin : g_first
         assign near_word = new_word;
      end else begin : g_mid
         assign near_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign far_word = '0;
      end else begin : g_inner
         assign far_word = cell_word[i+1];
      end

      dq_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .fill      (fill),
         .near_word (near_word),
         .far_word  (far_word),
         .load_word (new_word),
         .word      (cell_word[i])
      );
   end

   assign head_word = cell_word[0];

endmodule
